[hw/rtl/blit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter package
// Shared types, command codes, register indexes and the clipping function
// used by the rectangle fill and copy blitter.
// ----------------------------------------------------------------------------
package blit_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_MAX_STRIDE = 128;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_FILL  = 3'd2;
  localparam logic [2:0] OP_COPY  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_STRIDE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLIP_X,
    S_CLIP_Y,
    S_BASE_SRC,
    S_BASE_DST,
    S_PIX_RD,
    S_PIX_WR,
    S_CAPTURE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [17:0] lo;
    logic signed [17:0] hi;
  } clip_t;

  // Offsets along one axis for which both the source and the destination
  // stay inside [0, lim).
  function automatic clip_t clip_span(input logic signed [15:0] p,
                                      input logic signed [15:0] d,
                                      input logic signed [15:0] size,
                                      input logic [7:0] lim);
    logic signed [17:0] np;
    logic signed [17:0] nd;
    logic signed [17:0] lp;
    logic signed [17:0] ld;
    logic signed [17:0] sz;
    clip_t r;
    np = -{{2{p[15]}}, p};
    nd = -{{2{d[15]}}, d};
    lp = $signed({10'd0, lim}) - $signed({{2{p[15]}}, p});
    ld = $signed({10'd0, lim}) - $signed({{2{d[15]}}, d});
    sz = {{2{size[15]}}, size};
    r.lo = 18'sd0;
    if (np > r.lo) r.lo = np;
    if (nd > r.lo) r.lo = nd;
    r.hi = sz;
    if (lp < r.hi) r.hi = lp;
    if (ld < r.hi) r.hi = ld;
    return r;
  endfunction

endpackage

[hw/rtl/clipped_rect_fill_copy_blitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped rectangle fill and copy blitter
// Owns a 32-bit pixel memory addressed as row * stride + column and runs
// clear, pixel, fill, copy and read commands clipped to the visible surface.
// ----------------------------------------------------------------------------
// Usage:
// A command is taken when start is high and busy is low; the operands are
// captured in that cycle. busy stays high until the command has finished.
// The result (read_data, surface_valid) is shown for one cycle with done
// high, and the receiver takes it in that cycle; it cannot stall the block.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data, one transfer per cycle; cfg_ready is low while a
// command runs or is offered on start.
// Sequence: a disabled surface or unknown operation goes straight to the
// result. Otherwise two clipping steps through one shared clipping unit
// and two row base products through one shared multiplier come first; a
// command clipped to nothing then ends after the clipping steps. Clear,
// pixel and fill then write their pixels one after another, copy reads
// each pixel from memory and then writes it, and read reads its pixel and
// captures it; the result follows. Reset clears the configuration
// registers, the read data and the controller; the pixel memory keeps its
// contents and is undefined until written.
// ----------------------------------------------------------------------------
module clipped_rect_fill_copy_blitter #(
  parameter int MAX_WIDTH  = blit_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = blit_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_STRIDE = blit_pkg::DEF_MAX_STRIDE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         operation,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] size_w,
  input  logic signed [15:0] size_h,
  input  logic signed [15:0] dst_x,
  input  logic signed [15:0] dst_y,
  input  logic [31:0]        color,
  output logic [31:0]        read_data,
  output logic               surface_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int DEPTH = MAX_STRIDE * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  blit_pkg::state_t state, state_next;

  logic        surface_enabled;
  logic [7:0]  surface_width;
  logic [7:0]  surface_height;
  logic [7:0]  row_stride;

  logic [7:0]  w_eff;
  logic [7:0]  h_eff;
  logic [7:0]  s_eff;

  logic [2:0]         op;
  logic signed [15:0] cp_x;
  logic signed [15:0] cp_y;
  logic signed [15:0] cd_x;
  logic signed [15:0] cd_y;
  logic signed [15:0] cw;
  logic signed [15:0] ch;
  logic [31:0]        fill_color;

  logic [7:0]  sx0;
  logic [7:0]  dx0;
  logic [7:0]  sy0;
  logic [7:0]  dy0;
  logic [7:0]  sx;
  logic [7:0]  dx;
  logic [7:0]  ncol;
  logic [7:0]  col_left;
  logic [7:0]  row_left;
  logic        x_empty;
  logic [15:0] src_base;
  logic [15:0] dst_base;
  logic        src_ok;
  logic [31:0] rd;

  blit_pkg::clip_t    clip_res;
  logic signed [15:0] clip_p;
  logic signed [15:0] clip_d;
  logic signed [15:0] clip_size;
  logic [7:0]         clip_lim;
  logic               clip_empty;
  logic [7:0]         clip_src0;
  logic [7:0]         clip_dst0;
  logic [7:0]         clip_cnt;

  logic [7:0]  mul_a;
  logic [15:0] mul_p;

  logic [15:0]   src_full;
  logic [15:0]   dst_full;
  logic          src_in;
  logic          dst_in;
  logic [AW-1:0] src_idx;
  logic [AW-1:0] dst_idx;
  logic          last_pix;

  logic          mem_we;
  logic          mem_re;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_q;
  logic [31:0]   mem [DEPTH];

  logic accept;

  assign accept    = start && !busy;
  assign cfg_ready = !(busy || start);

  assign w_eff = (32'(surface_width)  > MAX_WIDTH)  ? 8'(MAX_WIDTH)  : surface_width;
  assign h_eff = (32'(surface_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : surface_height;
  assign s_eff = (32'(row_stride)     > MAX_STRIDE) ? 8'(MAX_STRIDE) : row_stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_enabled <= 1'b0;
      surface_width   <= 8'd0;
      surface_height  <= 8'd0;
      row_stride      <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        blit_pkg::REG_ENABLE: surface_enabled <= cfg_data[0];
        blit_pkg::REG_WIDTH:  surface_width   <= cfg_data;
        blit_pkg::REG_HEIGHT: surface_height  <= cfg_data;
        blit_pkg::REG_STRIDE: row_stride      <= cfg_data;
        default: ;
      endcase
    end
  end

  // One clipping unit serves the column axis and then the row axis.
  always_comb begin
    if (state == blit_pkg::S_CLIP_X) begin
      clip_p    = cp_x;
      clip_d    = cd_x;
      clip_size = cw;
      clip_lim  = w_eff;
    end else begin
      clip_p    = cp_y;
      clip_d    = cd_y;
      clip_size = ch;
      clip_lim  = h_eff;
    end
    clip_res   = blit_pkg::clip_span(clip_p, clip_d, clip_size, clip_lim);
    clip_empty = (clip_res.hi <= clip_res.lo);
    clip_src0  = 8'({{2{clip_p[15]}}, clip_p} + clip_res.lo);
    clip_dst0  = 8'({{2{clip_d[15]}}, clip_d} + clip_res.lo);
    clip_cnt   = 8'(clip_res.hi - clip_res.lo);
  end

  // One multiplier forms the source and then the destination row base.
  assign mul_a = (state == blit_pkg::S_BASE_SRC) ? sy0 : dy0;
  assign mul_p = mul_a * s_eff;

  assign src_full = src_base + {8'd0, sx};
  assign dst_full = dst_base + {8'd0, dx};
  assign src_in   = (32'(src_full) < DEPTH);
  assign dst_in   = (32'(dst_full) < DEPTH);
  assign src_idx  = AW'(src_full);
  assign dst_idx  = AW'(dst_full);
  assign last_pix = (col_left == 8'd1) && (row_left == 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blit_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      blit_pkg::S_IDLE: begin
        if (accept) begin
          if (!surface_enabled || operation > blit_pkg::OP_READ) begin
            state_next = blit_pkg::S_DONE;
          end else begin
            state_next = blit_pkg::S_CLIP_X;
          end
        end
      end
      blit_pkg::S_CLIP_X: begin
        state_next = blit_pkg::S_CLIP_Y;
      end
      blit_pkg::S_CLIP_Y: begin
        if (x_empty || clip_empty) begin
          state_next = blit_pkg::S_DONE;
        end else begin
          state_next = blit_pkg::S_BASE_SRC;
        end
      end
      blit_pkg::S_BASE_SRC: begin
        state_next = blit_pkg::S_BASE_DST;
      end
      blit_pkg::S_BASE_DST: begin
        if (op == blit_pkg::OP_COPY || op == blit_pkg::OP_READ) begin
          state_next = blit_pkg::S_PIX_RD;
        end else begin
          state_next = blit_pkg::S_PIX_WR;
        end
      end
      blit_pkg::S_PIX_RD: begin
        if (op == blit_pkg::OP_READ) begin
          state_next = blit_pkg::S_CAPTURE;
        end else begin
          state_next = blit_pkg::S_PIX_WR;
        end
      end
      blit_pkg::S_PIX_WR: begin
        if (last_pix) begin
          state_next = blit_pkg::S_DONE;
        end else if (op == blit_pkg::OP_COPY) begin
          state_next = blit_pkg::S_PIX_RD;
        end else begin
          state_next = blit_pkg::S_PIX_WR;
        end
      end
      blit_pkg::S_CAPTURE: begin
        state_next = blit_pkg::S_DONE;
      end
      blit_pkg::S_DONE: begin
        state_next = blit_pkg::S_IDLE;
      end
      default: begin
        state_next = blit_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy   = (state != blit_pkg::S_IDLE);
    done   = (state == blit_pkg::S_DONE);
    mem_re = (state == blit_pkg::S_PIX_RD) && src_in;
    mem_we = (state == blit_pkg::S_PIX_WR) && dst_in;
    if (op == blit_pkg::OP_COPY) begin
      mem_wdata = src_ok ? mem_q : 32'd0;
    end else begin
      mem_wdata = fill_color;
    end
  end

  assign read_data     = rd;
  assign surface_valid = surface_enabled && (surface_width != 8'd0) &&
                         (surface_height != 8'd0) && (row_stride >= surface_width);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[dst_idx] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[src_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 32'd0;
    end else if (accept) begin
      rd <= 32'd0;
    end else if (state == blit_pkg::S_CAPTURE && src_ok) begin
      rd <= mem_q;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      blit_pkg::S_IDLE: begin
        if (accept) begin
          op         <= operation;
          fill_color <= color;
          case (operation)
            blit_pkg::OP_CLEAR: begin
              cp_x <= 16'sd0;
              cp_y <= 16'sd0;
              cd_x <= 16'sd0;
              cd_y <= 16'sd0;
              cw   <= $signed({8'd0, w_eff});
              ch   <= $signed({8'd0, h_eff});
            end
            blit_pkg::OP_COPY: begin
              cp_x <= pos_x;
              cp_y <= pos_y;
              cd_x <= dst_x;
              cd_y <= dst_y;
              cw   <= size_w;
              ch   <= size_h;
            end
            blit_pkg::OP_FILL: begin
              cp_x <= pos_x;
              cp_y <= pos_y;
              cd_x <= pos_x;
              cd_y <= pos_y;
              cw   <= size_w;
              ch   <= size_h;
            end
            default: begin
              cp_x <= pos_x;
              cp_y <= pos_y;
              cd_x <= pos_x;
              cd_y <= pos_y;
              cw   <= 16'sd1;
              ch   <= 16'sd1;
            end
          endcase
        end
      end
      blit_pkg::S_CLIP_X: begin
        sx0     <= clip_src0;
        dx0     <= clip_dst0;
        ncol    <= clip_cnt;
        x_empty <= clip_empty;
      end
      blit_pkg::S_CLIP_Y: begin
        sy0      <= clip_src0;
        dy0      <= clip_dst0;
        row_left <= clip_cnt;
        col_left <= ncol;
        sx       <= sx0;
        dx       <= dx0;
      end
      blit_pkg::S_BASE_SRC: begin
        src_base <= mul_p;
      end
      blit_pkg::S_BASE_DST: begin
        dst_base <= mul_p;
      end
      blit_pkg::S_PIX_RD: begin
        src_ok <= src_in;
      end
      blit_pkg::S_PIX_WR: begin
        if (col_left != 8'd1) begin
          col_left <= col_left - 8'd1;
          sx       <= sx + 8'd1;
          dx       <= dx + 8'd1;
        end else if (row_left != 8'd1) begin
          row_left <= row_left - 8'd1;
          col_left <= ncol;
          sx       <= sx0;
          dx       <= dx0;
          src_base <= src_base + {8'd0, s_eff};
          dst_base <= dst_base + {8'd0, s_eff};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy stayed high after the result transfer");

  a_disabled_skip: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !surface_enabled) |=> (done && read_data == 32'd0))
    else $error("command on a disabled surface did not finish at once");

  a_counts_live: assert property (@(posedge clk) disable iff (rst)
    (state == blit_pkg::S_PIX_RD || state == blit_pkg::S_PIX_WR) |->
      (col_left != 8'd0 && row_left != 8'd0))
    else $error("pixel loop running with an empty span");

  a_read_only_data: assert property (@(posedge clk) disable iff (rst)
    (done && op != blit_pkg::OP_READ) |-> (read_data == 32'd0))
    else $error("read data set by a command that is not a read");
`endif

endmodule

[tb/sv/tb_clipped_rect_fill_copy_blitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the clipped rectangle fill and copy blitter
// Runs directed commands and then random traffic over several surface
// settings. A software image of the pixel memory is updated on every
// accepted command, and each strobed result is compared with it.
// ----------------------------------------------------------------------------
module tb_clipped_rect_fill_copy_blitter;

  localparam int STORE_WORDS = blit_pkg::DEF_MAX_STRIDE * blit_pkg::DEF_MAX_HEIGHT;
  localparam int STALL_LIMIT = 200000;
  localparam logic [2:0] OP_UNUSED_LO = blit_pkg::OP_READ + 3'd1;
  localparam logic [2:0] OP_UNUSED_HI = 3'b111;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [31:0]        color;
  } blit_cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        surface_valid;
  } blit_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               done;
  logic [2:0]         operation = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] size_w = '0;
  logic signed [15:0] size_h = '0;
  logic signed [15:0] dst_x = '0;
  logic signed [15:0] dst_y = '0;
  logic [31:0]        color = '0;
  logic [31:0]        read_data;
  logic               surface_valid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  logic [31:0]  pixels [STORE_WORDS];
  logic         en_reg = 1'b0;
  logic [7:0]   width_reg = '0;
  logic [7:0]   height_reg = '0;
  logic [7:0]   stride_reg = '0;
  blit_result_t readback_q [$];
  blit_result_t oldest;

  int  error_count = 0;
  int  results_checked = 0;
  int  cmds_sent = 0;
  int  settings_used = 0;
  int  op_count [8];
  int  stall_cycles = 0;
  bit  steady_issue = 1'b0;

  clipped_rect_fill_copy_blitter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .operation(operation), .pos_x(pos_x), .pos_y(pos_y),
    .size_w(size_w), .size_h(size_h), .dst_x(dst_x), .dst_y(dst_y),
    .color(color), .read_data(read_data), .surface_valid(surface_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int vis_width();
    return (width_reg > blit_pkg::DEF_MAX_WIDTH) ? blit_pkg::DEF_MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int vis_height();
    return (height_reg > blit_pkg::DEF_MAX_HEIGHT) ? blit_pkg::DEF_MAX_HEIGHT
                                                   : int'(height_reg);
  endfunction

  function automatic int vis_stride();
    return (stride_reg > blit_pkg::DEF_MAX_STRIDE) ? blit_pkg::DEF_MAX_STRIDE
                                                   : int'(stride_reg);
  endfunction

  function automatic bit on_surface(input int x, input int y);
    return x >= 0 && y >= 0 && x < vis_width() && y < vis_height();
  endfunction

  function automatic void put_pixel(input int x, input int y, input logic [31:0] v);
    int a;
    a = y * vis_stride() + x;
    if (a >= 0 && a < STORE_WORDS) pixels[a] = v;
  endfunction

  function automatic logic [31:0] get_pixel(input int x, input int y);
    int a;
    a = y * vis_stride() + x;
    if (a >= 0 && a < STORE_WORDS) return pixels[a];
    return '0;
  endfunction

  // Updates the pixel image for one command and returns the result it yields.
  function automatic blit_result_t apply_command(input blit_cmd_t c);
    blit_result_t res;
    int px, py, sw, sh, qx, qy, vw, vh, x0, x1, y0, y1, i, j;
    px = $signed(c.x);
    py = $signed(c.y);
    sw = $signed(c.w);
    sh = $signed(c.h);
    qx = $signed(c.dx);
    qy = $signed(c.dy);
    vw = vis_width();
    vh = vis_height();
    res.read_data = '0;
    res.surface_valid = en_reg && width_reg != 0 && height_reg != 0 &&
                        stride_reg >= width_reg;
    if (en_reg) begin
      case (c.op)
        blit_pkg::OP_CLEAR: begin
          for (j = 0; j < vh; j++)
            for (i = 0; i < vw; i++) put_pixel(i, j, c.color);
        end
        blit_pkg::OP_PIXEL: begin
          if (on_surface(px, py)) put_pixel(px, py, c.color);
        end
        blit_pkg::OP_FILL: begin
          if (sw > 0 && sh > 0) begin
            x0 = (px > 0) ? px : 0;
            x1 = (px + sw < vw) ? px + sw : vw;
            y0 = (py > 0) ? py : 0;
            y1 = (py + sh < vh) ? py + sh : vh;
            for (j = y0; j < y1; j++)
              for (i = x0; i < x1; i++) put_pixel(i, j, c.color);
          end
        end
        blit_pkg::OP_COPY: begin
          if (sw > 0 && sh > 0) begin
            // Offsets at which both the source and the destination are visible.
            x0 = 0;
            if (-px > x0) x0 = -px;
            if (-qx > x0) x0 = -qx;
            x1 = sw;
            if (vw - px < x1) x1 = vw - px;
            if (vw - qx < x1) x1 = vw - qx;
            y0 = 0;
            if (-py > y0) y0 = -py;
            if (-qy > y0) y0 = -qy;
            y1 = sh;
            if (vh - py < y1) y1 = vh - py;
            if (vh - qy < y1) y1 = vh - qy;
            for (j = y0; j < y1; j++)
              for (i = x0; i < x1; i++)
                put_pixel(qx + i, qy + j, get_pixel(px + i, py + j));
          end
        end
        blit_pkg::OP_READ: begin
          if (on_surface(px, py)) res.read_data = get_pixel(px, py);
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic blit_cmd_t mk_cmd(input logic [2:0] op, input int x, input int y,
                                       input int w, input int h, input int dx,
                                       input int dy, input logic [31:0] c);
    blit_cmd_t cmd;
    cmd.op = op;
    cmd.x = x[15:0];
    cmd.y = y[15:0];
    cmd.w = w[15:0];
    cmd.h = h[15:0];
    cmd.dx = dx[15:0];
    cmd.dy = dy[15:0];
    cmd.color = c;
    return cmd;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Results are taken in the cycle that done marks; the block cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (readback_q.size() == 0) begin
        flag_error($sformatf("result with no command outstanding: data %h valid %b",
                             read_data, surface_valid));
      end else begin
        oldest = readback_q.pop_front();
        results_checked++;
        if (read_data !== oldest.read_data)
          flag_error($sformatf("read_data %h, predicted %h", read_data, oldest.read_data));
        if (surface_valid !== oldest.surface_valid)
          flag_error($sformatf("surface_valid %b, predicted %b", surface_valid,
                               oldest.surface_valid));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
      $display("** clipped_rect_fill_copy_blitter: FAILED **");
      $finish;
    end
  end

  // Leaves start high after the transfer so that a back-to-back command
  // needs only one assignment to it in that time step.
  task automatic send_cmd(input blit_cmd_t c);
    int gap;
    gap = steady_issue ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= c.op;
    pos_x <= c.x;
    pos_y <= c.y;
    size_w <= c.w;
    size_h <= c.h;
    dst_x <= c.dx;
    dst_y <= c.dy;
    color <= c.color;
    do @(posedge clk); while (busy);
    readback_q.push_back(apply_command(c));
    cmds_sent++;
    op_count[c.op]++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_surface(input logic en, input logic [7:0] w, input logic [7:0] h,
                             input logic [7:0] s);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    logic [7:0] junk;
    int i;
    wait_idle();
    junk = 8'($urandom());
    idx[0] = blit_pkg::REG_ENABLE;
    idx[1] = blit_pkg::REG_WIDTH;
    idx[2] = blit_pkg::REG_HEIGHT;
    idx[3] = blit_pkg::REG_STRIDE;
    val[0] = {junk[7:1], en};
    val[1] = w;
    val[2] = h;
    val[3] = s;
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        blit_pkg::REG_ENABLE: en_reg = val[i][0];
        blit_pkg::REG_WIDTH:  width_reg = val[i];
        blit_pkg::REG_HEIGHT: height_reg = val[i];
        blit_pkg::REG_STRIDE: stride_reg = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [15:0] rand_coord(input int lim);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      v = $urandom_range(0, lim + 7);
      v = v - 4;
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = -1;
        default: v = lim;
      endcase
    end else begin
      v = $urandom_range(0, 65535);
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] rand_size();
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      v = $urandom_range(1, 16);
    end else if (r < 86) begin
      v = $urandom_range(0, 3);
      v = -v;
    end else if (r < 88) begin
      v = -32768;
    end else if (r < 95) begin
      v = $urandom_range(0, 65535);
    end else begin
      v = ($urandom_range(0, 1) != 0) ? 32767 : blit_pkg::DEF_MAX_WIDTH;
    end
    return v[15:0];
  endfunction

  function automatic blit_cmd_t random_cmd();
    blit_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) c.op = blit_pkg::OP_CLEAR;
    else if (r < 26) c.op = blit_pkg::OP_PIXEL;
    else if (r < 50) c.op = blit_pkg::OP_FILL;
    else if (r < 74) c.op = blit_pkg::OP_COPY;
    else if (r < 96) c.op = blit_pkg::OP_READ;
    else c.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    c.x = rand_coord(vis_width());
    c.y = rand_coord(vis_height());
    c.w = rand_size();
    c.h = rand_size();
    c.dx = rand_coord(vis_width());
    c.dy = rand_coord(vis_height());
    c.color = $urandom();
    return c;
  endfunction

  function automatic logic [7:0] rand_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(1, blit_pkg::DEF_MAX_WIDTH));
  endfunction

  task automatic test_disabled_surface();
    send_cmd(mk_cmd(blit_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 32'hdeadbeef));
    send_cmd(mk_cmd(blit_pkg::OP_FILL, 0, 0, 4, 4, 0, 0, 32'h0bad0bad));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 32'h0));
  endtask

  task automatic test_full_clear();
    set_surface(1'b1, 8'd128, 8'd128, 8'd128);
    send_cmd(mk_cmd(blit_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 32'hffffffff));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 127, 127, 0, 0, 0, 0, 32'h0));
  endtask

  task automatic test_pixel_write_read();
    send_cmd(mk_cmd(blit_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 32'h00000000));
    send_cmd(mk_cmd(blit_pkg::OP_PIXEL, 127, 127, -1, -1, -1, -1, 32'h12345678));
    send_cmd(mk_cmd(blit_pkg::OP_PIXEL, -32768, 32767, 0, 0, 0, 0, 32'h55aa55aa));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 127, 127, 0, 0, 0, 0, 32'h0));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 128, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 32767, -32768, 0, 0, 0, 0, 32'h0));
  endtask

  task automatic test_fill_clipping();
    send_cmd(mk_cmd(blit_pkg::OP_FILL, -5, -5, 10, 10, 0, 0, 32'ha5a5a5a5));
    send_cmd(mk_cmd(blit_pkg::OP_FILL, 120, 124, 32767, 32767, 0, 0, 32'h5a5a5a5a));
    send_cmd(mk_cmd(blit_pkg::OP_FILL, 10, 10, 0, 5, 0, 0, 32'h11111111));
    send_cmd(mk_cmd(blit_pkg::OP_FILL, 10, 10, 5, -32768, 0, 0, 32'h22222222));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 4, 4, 0, 0, 0, 0, 32'h0));
  endtask

  // A one-column shift to the right smears the first pixel of each row along that row.
  task automatic test_copy_overlap();
    send_cmd(mk_cmd(blit_pkg::OP_COPY, 0, 0, 8, 2, 1, 0, 32'h0));
    send_cmd(mk_cmd(blit_pkg::OP_COPY, 120, 120, 32767, 32767, -3, -3, 32'h0));
    send_cmd(mk_cmd(blit_pkg::OP_COPY, 0, 0, -1, 4, 20, 20, 32'h0));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 8, 0, 0, 0, 0, 0, 32'h0));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 32'h0));
  endtask

  task automatic test_unknown_ops();
    int op;
    for (op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      send_cmd(mk_cmd(3'(op), 3, 3, 2, 2, 5, 5, 32'hcafef00d));
  endtask

  task automatic test_register_extremes();
    set_surface(1'b1, 8'hff, 8'hff, 8'hff);
    send_cmd(mk_cmd(blit_pkg::OP_READ, 127, 127, 0, 0, 0, 0, 32'h0));
    // With the stride below the width, column 60 of row 0 is column 10 of row 1.
    set_surface(1'b1, 8'd100, 8'd4, 8'd50);
    send_cmd(mk_cmd(blit_pkg::OP_PIXEL, 60, 0, 0, 0, 0, 0, 32'h87654321));
    send_cmd(mk_cmd(blit_pkg::OP_READ, 10, 1, 0, 0, 0, 0, 32'h0));
  endtask

  task automatic test_random_traffic();
    int phase, n;
    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_surface(1'b1, 8'd16, 8'd16, 8'd16);
        1: set_surface(1'b1, 8'hff, 8'hff, 8'hff);
        2: set_surface(1'b1, 8'd0, 8'd16, 8'd16);
        3: set_surface(1'b1, 8'd40, 8'd30, 8'd0);
        4: set_surface(1'b0, 8'd128, 8'd128, 8'd128);
        5: set_surface(1'b1, 8'd1, 8'd1, 8'd1);
        6: set_surface(1'b1, 8'd24, 8'd0, 8'd24);
        default: set_surface($urandom_range(0, 9) != 0, rand_dim(), rand_dim(), rand_dim());
      endcase
      steady_issue = (phase == 0 || phase == 7);
      for (n = 0; n < 8; n++) send_cmd(random_cmd());
    end
    steady_issue = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_disabled_surface();
    test_full_clear();
    test_pixel_write_read();
    test_fill_clipping();
    test_copy_overlap();
    test_unknown_ops();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (16) @(posedge clk);
    $display("Covered %0d commands: %0d clear, %0d pixel, %0d fill, %0d copy, %0d read,",
             cmds_sent, op_count[blit_pkg::OP_CLEAR], op_count[blit_pkg::OP_PIXEL],
             op_count[blit_pkg::OP_FILL], op_count[blit_pkg::OP_COPY],
             op_count[blit_pkg::OP_READ]);
    $display("the rest undefined codes, over %0d surface settings; %0d results compared.",
             settings_used, results_checked);
    if (error_count == 0) begin
      $display("** clipped_rect_fill_copy_blitter: PASSED **");
    end else begin
      $display("** clipped_rect_fill_copy_blitter: FAILED **");
    end
    $finish;
  end

endmodule
